// ===== hdl/mcrs_pkg.sv =====
// Package for the Monte Carlo complex root search core.
// Holds widths, reset values, command/status structs and the outcome codes.
// No dependencies.
package mcrs_pkg;

  localparam int unsigned StepW = 31;
  localparam int unsigned LimitW = 16;
  localparam int unsigned CapW = 32;
  localparam int unsigned CoordW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned FracW = 24;

  localparam logic [StepW-1:0] InitialStepRst = 31'd16777216;
  localparam logic [LimitW-1:0] TrialLimitRst = 16'd10;
  localparam logic [StepW-1:0] ToleranceRst = 31'd168;
  localparam logic [CapW-1:0] IterationCapRst = 32'hFFFF_FFFF;

  localparam logic [CfgIdxW-1:0] RegInitialStep = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTrialLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTolerance = 2'd2;
  localparam logic [CfgIdxW-1:0] RegIterationCap = 2'd3;

  localparam logic [1:0] OutcomeResidual = 2'd0;
  localparam logic [1:0] OutcomeStep = 2'd1;
  localparam logic [1:0] OutcomeCap = 2'd2;

  localparam logic [15:0] LcgMul = 16'd2053;
  localparam logic [15:0] LcgAdd = 16'd13849;
  localparam logic [15:0] LcgSeed = 16'd1;

  // Datapath operations issued by the controller states.
  typedef enum logic [3:0] {
    OpNone,
    OpLoad,
    OpTrialX,
    OpTrialY,
    OpMulXx,
    OpMulYy,
    OpMulXy,
    OpSumUv,
    OpSqU,
    OpSqV,
    OpMag,
    OpTol,
    OpUpdate
  } op_e;

  typedef struct packed {
    op_e  op;
    logic use_best;
  } cmd_t;

  typedef struct packed {
    logic step_small;
    logic cap_hit;
    logic improved;
    logic below_tol;
    logic halve;
  } status_t;

endpackage

// ===== hdl/monte_carlo_complex_root_search_core.sv =====
// Monte Carlo complex root search core: top level joining controller and datapath.
// Throughput: one search at a time; the next item is taken once the result register is free.
// Each trial uses the shared 32x32 signed multiplier three times.
// Reset clears all control state and restores the register defaults; no clearing pass.
module monte_carlo_complex_root_search_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mcrs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mcrs_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [63:0]                       s_axis_tdata,   // start_x, start_y
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [71:0]                       m_axis_tdata    // root_x, root_y, outcome
);
  import mcrs_pkg::*;

  logic [StepW-1:0] init_q, tol_q;
  logic [LimitW-1:0] limit_q;
  logic [CapW-1:0] cap_q;
  cmd_t cmd;
  status_t status;
  logic signed [31:0] bx, by;
  logic [1:0] outcome;
  logic capture;
  logic [63:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= InitialStepRst;
      limit_q <= TrialLimitRst;
      tol_q <= ToleranceRst;
      cap_q <= IterationCapRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegInitialStep: init_q <= cfg_data_i[StepW-1:0];
        RegTrialLimit: limit_q <= cfg_data_i[LimitW-1:0];
        RegTolerance: tol_q <= cfg_data_i[StepW-1:0];
        RegIterationCap: cap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) res_q <= {by, bx};
  end

  mcrs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .outcome_o(outcome), .capture_o(capture),
    .cmd_o(cmd), .status_i(status)
  );

  mcrs_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .start_x_i(s_axis_tdata[31:0]), .start_y_i(s_axis_tdata[63:32]),
    .initial_step_i(init_q), .trial_limit_i(limit_q),
    .tolerance_i(tol_q), .iteration_cap_i(cap_q),
    .status_o(status), .best_x_o(bx), .best_y_o(by)
  );

  assign m_axis_tdata = {6'd0, outcome, res_q};

endmodule

// ===== hdl/mcrs_datapath.sv =====
// Datapath of the root search: coordinates, residual evaluation, step and counters.
// One 32x32 signed multiplier is shared over the steps of each trial. Uses mcrs_pkg.
module mcrs_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mcrs_pkg::cmd_t                  cmd_i,
  input  logic signed [31:0]              start_x_i,
  input  logic signed [31:0]              start_y_i,
  input  logic [mcrs_pkg::StepW-1:0]      initial_step_i,
  input  logic [mcrs_pkg::LimitW-1:0]     trial_limit_i,
  input  logic [mcrs_pkg::StepW-1:0]      tolerance_i,
  input  logic [mcrs_pkg::CapW-1:0]       iteration_cap_i,
  output mcrs_pkg::status_t               status_o,
  output logic signed [31:0]              best_x_o,
  output logic signed [31:0]              best_y_o
);
  import mcrs_pkg::*;

  logic [15:0] lcg_q, lcg_d, lcg_next;
  logic signed [31:0] bx_q, by_q, tx_q, ty_q;
  logic [31:0] step_q;
  logic [15:0] fail_q;
  logic [31:0] total_q;
  logic [63:0] best_q, mag_q;
  logic signed [63:0] xx_q, yy_q, xy_q;
  logic signed [66:0] u_q, v_q;
  logic [63:0] su_q;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [63:0] prod_t;
  logic signed [31:0] ex, ey;
  logic [31:0] lo32;
  logic [15:0] lcg_mul;
  logic signed [34:0] tsum;
  logic signed [31:0] tclamp;
  logic [48:0] off_w;
  logic [66:0] abs_u;
  logic [63:0] sq_w;
  logic [64:0] mag_sum;
  logic [61:0] tol_sq;
  logic improve;

  assign lcg_mul = 16'(lcg_q * LcgMul);
  assign lcg_next = lcg_mul + LcgAdd;
  assign off_w = ({17'd0, step_q} * {33'd0, lcg_next}) >> 15;
  assign ex = bx_q;
  assign ey = by_q;
  assign tsum = 35'(signed'(cmd_i.op == OpTrialX ? bx_q : by_q)) - 35'(step_q)
              + 35'(off_w[33:0]);
  assign tclamp = (tsum > 35'sd2147483647) ? 32'sh7FFF_FFFF :
                  (tsum < -35'sd2147483648) ? 32'sh8000_0000 : tsum[31:0];

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OpMulXx: begin ma = cmd_i.use_best ? tx_q : ex; mb = ma; end
      OpMulYy: begin ma = cmd_i.use_best ? ty_q : ey; mb = ma; end
      OpMulXy: begin ma = cmd_i.use_best ? tx_q : ex; mb = cmd_i.use_best ? ty_q : ey; end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign prod = ma * mb;
  // Division by 2^24 truncating toward zero.
  assign prod_t = (prod < 0) ? -((-prod) >>> FracW) : (prod >>> FracW);

  always_comb begin
    abs_u = (cmd_i.op == OpSqU) ? (u_q[66] ? 67'(-u_q) : 67'(u_q))
                                : (v_q[66] ? 67'(-v_q) : 67'(v_q));
    lo32 = abs_u[31:0];
    sq_w = (|abs_u[66:32]) ? 64'hFFFF_FFFF_FFFF_FFFF : lo32 * lo32;
  end
  assign mag_sum = {1'b0, su_q} + {1'b0, sq_w};
  assign tol_sq = tolerance_i * tolerance_i;
  assign improve = mag_q < best_q;
  assign lcg_d = lcg_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q <= LcgSeed;
      bx_q <= '0;
      by_q <= '0;
      tx_q <= '0;
      ty_q <= '0;
      step_q <= '0;
      fail_q <= '0;
      total_q <= '0;
      best_q <= '0;
      mag_q <= '0;
      xx_q <= '0;
      yy_q <= '0;
      xy_q <= '0;
      u_q <= '0;
      v_q <= '0;
      su_q <= '0;
    end else begin
      case (cmd_i.op)
        OpLoad: begin
          lcg_q <= LcgSeed;
          bx_q <= start_x_i;
          by_q <= start_y_i;
          step_q <= {1'b0, initial_step_i};
          fail_q <= '0;
          total_q <= '0;
        end
        OpTrialX: begin lcg_q <= lcg_d; tx_q <= tclamp; end
        OpTrialY: begin lcg_q <= lcg_d; ty_q <= tclamp; end
        OpMulXx: xx_q <= prod_t;
        OpMulYy: yy_q <= prod_t;
        OpMulXy: xy_q <= prod_t;
        OpSumUv: begin
          u_q <= 67'(xx_q) * 67'sd3 - 67'(yy_q) * 67'sd5
               - 67'(signed'(cmd_i.use_best ? tx_q : ex)) * 67'sd2 + 67'sd184549376;
          v_q <= 67'(xy_q) * 67'sd7 - 67'(signed'(cmd_i.use_best ? ty_q : ey)) * 67'sd13;
        end
        OpSqU: su_q <= sq_w;
        OpSqV: mag_q <= mag_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : mag_sum[63:0];
        OpMag: best_q <= mag_q;
        OpUpdate: begin
          total_q <= total_q + 32'd1;
          if (improve) begin
            fail_q <= '0;
            bx_q <= tx_q;
            by_q <= ty_q;
            best_q <= mag_q;
          end else if (17'(fail_q) + 17'd1 >= 17'(trial_limit_i)) begin
            fail_q <= '0;
            step_q <= step_q >> 1;
          end else begin
            fail_q <= fail_q + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign status_o.step_small = (step_q < {1'b0, tolerance_i}) || (step_q == '0);
  assign status_o.cap_hit = total_q >= iteration_cap_i;
  assign status_o.improved = improve;
  assign status_o.below_tol = mag_q < {2'b0, tol_sq};
  assign status_o.halve = 1'b0;
  assign best_x_o = bx_q;
  assign best_y_o = by_q;

endmodule

// ===== hdl/mcrs_ctrl.sv =====
// Controller state machine of the root search core.
// Sequences load, trial draws, residual steps and the stop tests. Uses mcrs_pkg.
module mcrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        outcome_o,
  output logic              capture_o,
  output mcrs_pkg::cmd_t    cmd_o,
  input  mcrs_pkg::status_t status_i
);
  import mcrs_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StXx, StYy, StXy, StUv, StSqU, StSqV, StMag,
    StTest, StTx, StTy, StUpdate, StDone
  } state_e;

  state_e state_q;
  logic trial_q;
  logic out_valid_q;
  logic [1:0] outcome_q;

  always_comb begin
    cmd_o.use_best = trial_q;
    case (state_q)
      StIdle: cmd_o.op = (in_valid_i && !out_valid_q) ? OpLoad : OpNone;
      StXx: cmd_o.op = OpMulXx;
      StYy: cmd_o.op = OpMulYy;
      StXy: cmd_o.op = OpMulXy;
      StUv: cmd_o.op = OpSumUv;
      StSqU: cmd_o.op = OpSqU;
      StSqV: cmd_o.op = OpSqV;
      StMag: cmd_o.op = trial_q ? OpNone : OpMag;
      StTx: cmd_o.op = OpTrialX;
      StTy: cmd_o.op = OpTrialY;
      StUpdate: cmd_o.op = OpUpdate;
      default: cmd_o.op = OpNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      trial_q <= 1'b0;
      out_valid_q <= 1'b0;
      outcome_q <= OutcomeResidual;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: if (in_valid_i && !out_valid_q) begin
          trial_q <= 1'b0;
          state_q <= StXx;
        end
        StXx: state_q <= StYy;
        StYy: state_q <= StXy;
        StXy: state_q <= StUv;
        StUv: state_q <= StSqU;
        StSqU: state_q <= StSqV;
        StSqV: state_q <= trial_q ? StUpdate : StMag;
        StMag: state_q <= StTest;
        StTest: begin
          if (status_i.step_small) begin
            outcome_q <= OutcomeStep;
            state_q <= StDone;
          end else if (status_i.cap_hit) begin
            outcome_q <= OutcomeCap;
            state_q <= StDone;
          end else begin
            trial_q <= 1'b1;
            state_q <= StTx;
          end
        end
        StTx: state_q <= StTy;
        StTy: state_q <= StXx;
        StUpdate: begin
          if (status_i.improved && status_i.below_tol) begin
            outcome_q <= OutcomeResidual;
            state_q <= StDone;
          end else begin
            state_q <= StTest;
          end
        end
        StDone: begin
          out_valid_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign outcome_o = outcome_q;
  assign capture_o = (state_q == StDone);

  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone |=> out_valid_q) else $error("result not raised");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(outcome_q))
    else $error("result dropped");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !in_ready_o) else $error("ready while busy");

endmodule
